### hdl/wist_pkg.sv
// Shared types, constants and register codes for the windowed interval spray timer.
package wist_pkg;

	localparam logic [17:0] SEC_PER_DAY    = 18'd86400;
	localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
	localparam logic [16:0] SEC_PER_MINUTE = 17'd60;
	localparam logic [10:0] MIN_PER_HOUR   = 11'd60;
	localparam logic [6:0]  MAX_SPRAY_SEC  = 7'd99;
	localparam logic [3:0]  MAX_INTERVAL_H = 4'd12;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AUTO_ENABLE       = 3'd0,
		REG_WINDOW_ON_HOUR    = 3'd1,
		REG_WINDOW_ON_MINUTE  = 3'd2,
		REG_WINDOW_OFF_HOUR   = 3'd3,
		REG_WINDOW_OFF_MINUTE = 3'd4,
		REG_INTERVAL_HOURS    = 3'd5,
		REG_SPRAY_SECONDS     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic       relay_now;
		logic [4:0] tick_hour;
		logic [5:0] tick_minute;
		logic [5:0] tick_second;
	} in_t;

	typedef struct packed {
		logic relay_wanted;
		logic relay_change;
		logic range_error;
	} out_t;

	// Settings as the decision logic sees them, derived from the registers.
	typedef struct packed {
		logic        auto_enable;
		logic        range_bad;
		logic [10:0] on_min;
		logic [10:0] off_min;
		logic [15:0] gap_seconds;
		logic [6:0]  spray_seconds;
	} cfg_t;

	// One request held in the input stage, time already folded to minutes and seconds.
	typedef struct packed {
		logic        relay_now;
		logic [10:0] now_min;
		logic [16:0] now_sec;
	} tick_t;

endpackage

### hdl/wist_cfg.sv
// Configuration register file and derived window and interval settings.
module wist_cfg
	import wist_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	logic       auto_enable_q;
	logic [4:0] on_hour_q;
	logic [5:0] on_minute_q;
	logic [4:0] off_hour_q;
	logic [5:0] off_minute_q;
	logic [3:0] interval_hours_q;
	logic [6:0] spray_seconds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_enable_q    <= 1'b0;
			on_hour_q        <= '0;
			on_minute_q      <= '0;
			off_hour_q       <= '0;
			off_minute_q     <= '0;
			interval_hours_q <= 4'd1;
			spray_seconds_q  <= 7'd1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_AUTO_ENABLE:       auto_enable_q    <= wr_data[0];
				REG_WINDOW_ON_HOUR:    on_hour_q        <= wr_data[4:0];
				REG_WINDOW_ON_MINUTE:  on_minute_q      <= wr_data[5:0];
				REG_WINDOW_OFF_HOUR:   off_hour_q       <= wr_data[4:0];
				REG_WINDOW_OFF_MINUTE: off_minute_q     <= wr_data[5:0];
				REG_INTERVAL_HOURS:    interval_hours_q <= wr_data[3:0];
				REG_SPRAY_SECONDS:     spray_seconds_q  <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.auto_enable   = auto_enable_q;
		cfg.range_bad     = (spray_seconds_q == 7'd0) || (spray_seconds_q > MAX_SPRAY_SEC) ||
		                    (interval_hours_q == 4'd0) || (interval_hours_q > MAX_INTERVAL_H);
		cfg.on_min        = 11'(on_hour_q) * MIN_PER_HOUR + 11'(on_minute_q);
		cfg.off_min       = 11'(off_hour_q) * MIN_PER_HOUR + 11'(off_minute_q);
		cfg.gap_seconds   = 16'(17'(interval_hours_q) * SEC_PER_HOUR);
		cfg.spray_seconds = spray_seconds_q;
	end

endmodule

### hdl/wist_decide.sv
// Per-tick relay decision and next spray mark.
module wist_decide
	import wist_pkg::*;
(
	input  tick_t       tick,
	input  cfg_t        cfg,
	input  logic [16:0] mark,
	output out_t        result,
	output logic        mark_we,
	output logic [16:0] mark_next
);

	logic        win_open;
	logic [17:0] wrap_sum;
	logic [17:0] elapsed;
	logic        wanted;
	logic        err;

	always_comb begin
		if (cfg.on_min == cfg.off_min) begin
			win_open = 1'b0;
		end else if (cfg.on_min < cfg.off_min) begin
			win_open = (tick.now_min >= cfg.on_min) && (tick.now_min < cfg.off_min);
		end else begin
			win_open = (tick.now_min >= cfg.on_min) || (tick.now_min < cfg.off_min);
		end
	end

	// Elapsed seconds since the mark, across midnight; saturate at zero.
	always_comb begin
		wrap_sum = SEC_PER_DAY + 18'(tick.now_sec);
		if (tick.now_sec >= mark) begin
			elapsed = 18'(tick.now_sec - mark);
		end else if (wrap_sum >= 18'(mark)) begin
			elapsed = wrap_sum - 18'(mark);
		end else begin
			elapsed = '0;
		end
	end

	always_comb begin
		wanted    = tick.relay_now;
		err       = 1'b0;
		mark_we   = 1'b0;
		mark_next = tick.now_sec;
		if (!cfg.auto_enable) begin
			wanted = tick.relay_now;
		end else if (cfg.range_bad) begin
			err = 1'b1;
		end else if (!win_open) begin
			wanted    = 1'b0;
			mark_we   = 1'b1;
			mark_next = '0;
		end else if (mark == 17'd0) begin
			wanted  = 1'b1;
			mark_we = 1'b1;
		end else if (tick.relay_now) begin
			if (elapsed >= 18'(cfg.spray_seconds)) begin
				wanted  = 1'b0;
				mark_we = 1'b1;
			end
		end else if (elapsed >= 18'(cfg.gap_seconds)) begin
			wanted  = 1'b1;
			mark_we = 1'b1;
		end
		result.relay_wanted = wanted;
		result.relay_change = wanted ^ tick.relay_now;
		result.range_error  = err;
	end

endmodule

### hdl/windowed_interval_spray_timer_top.sv
// Top level of the windowed interval spray timer: input stage, mark register, result register.
//
// Each request is one time-of-day tick plus the present relay state, and yields exactly one
// result: the wanted relay state, a change flag and a range error flag. The block takes one
// request per clock cycle while the result side is not stalled. A request is registered in
// the input stage, and its result is loaded into the result register once that register is
// free or being drained. The spray mark register is read and rewritten in the cycle a
// request leaves the input stage, so the next request already sees the updated mark. The
// input stage converts the tick to minutes and seconds of the day; the decision logic
// compares against the daily window (which may span midnight; equal on and off times keep
// it closed) and against the spray length and interval, with midnight rollover of the
// elapsed time. The result register holds a stalled result while the input stage still
// takes one more request. Write configuration only while no request is in flight; writes
// are always taken (cfg_ready high).
module windowed_interval_spray_timer_top
	import wist_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t        cfg;
	logic        valid_s1;
	tick_t       tick_s1;
	logic [16:0] mark_q;
	logic        out_valid_q;
	out_t        out_data_q;
	out_t        result;
	logic        mark_we;
	logic [16:0] mark_next;
	logic        advance;
	logic        in_take;

	assign cfg_ready = 1'b1;

	wist_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move the staged request on whenever the result register is free or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input stage: fold the tick into minute of day and second of day.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_s1.relay_now <= in_data.relay_now;
			tick_s1.now_min   <= 11'(in_data.tick_hour) * MIN_PER_HOUR +
			                     11'(in_data.tick_minute);
			tick_s1.now_sec   <= 17'(in_data.tick_hour) * SEC_PER_HOUR +
			                     17'(in_data.tick_minute) * SEC_PER_MINUTE +
			                     17'(in_data.tick_second);
		end
	end

	wist_decide u_decide (
		.tick      (tick_s1),
		.cfg       (cfg),
		.mark      (mark_q),
		.result    (result),
		.mark_we   (mark_we),
		.mark_next (mark_next)
	);

	// Update the mark as the request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
		end else if (valid_s1 && advance && mark_we) begin
			mark_q <= mark_next;
		end
	end

	// Result register: hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.range_error) |-> !out_data.relay_change)
		else $error("range error result requests a relay change");

	a_disabled_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && !cfg.auto_enable) |=> $stable(mark_q))
		else $error("mark moved while automation disabled");

	a_closed_off: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && mark_we && (mark_next == 17'd0) && !result.relay_wanted)
		|=> (out_valid_q && !out_data_q.relay_wanted))
		else $error("mark cleared but result lost");

endmodule

### tb/windowed_interval_spray_timer_top_tb.sv
// Self-checking testbench for the windowed interval spray timer top level.
`timescale 1ns / 100ps

module windowed_interval_spray_timer_top_tb;
	import wist_pkg::*;

	localparam int unsigned DAY_SEC      = 86400;
	localparam int unsigned HOUR_SEC     = 3600;
	localparam int unsigned MINUTE_SEC   = 60;
	localparam int unsigned SPRAY_MAX    = 99;
	localparam int unsigned INTERVAL_MAX = 12;

	// Index 7 is decoded by no register; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam int RANDOM_PHASES   = 25;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int DRAIN_CYCLES    = 4;
	localparam int CYCLE_LIMIT     = 1000000;

	// Relay predictor plus the queue of results it expects, oldest first.
	class relay_scoreboard;
		bit          auto_en;
		int unsigned on_hour, on_minute, off_hour, off_minute;
		int unsigned interval_h, spray_len;
		int unsigned mark_sec;
		bit          last_wanted;
		int          errors;
		out_t        expected_q[$];

		function new();
			auto_en = 0;
			on_hour = 0;
			on_minute = 0;
			off_hour = 0;
			off_minute = 0;
			interval_h = 1;
			spray_len = 1;
			mark_sec = 0;
			last_wanted = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_AUTO_ENABLE:       auto_en = val[0];
				REG_WINDOW_ON_HOUR:    on_hour = val[4:0];
				REG_WINDOW_ON_MINUTE:  on_minute = val[5:0];
				REG_WINDOW_OFF_HOUR:   off_hour = val[4:0];
				REG_WINDOW_OFF_MINUTE: off_minute = val[5:0];
				REG_INTERVAL_HOURS:    interval_h = val[3:0];
				REG_SPRAY_SECONDS:     spray_len = val[6:0];
				default: ;
			endcase
		endfunction

		function bit window_open(int unsigned now_min);
			int unsigned on_min;
			int unsigned off_min;
			on_min = on_hour * 60 + on_minute;
			off_min = off_hour * 60 + off_minute;
			if (on_min == off_min)
				return 0;
			if (on_min < off_min)
				return now_min >= on_min && now_min < off_min;
			return now_min >= on_min || now_min < off_min;
		endfunction

		function out_t predict_relay(in_t t);
			out_t        r;
			int unsigned now_sec;
			int unsigned elapsed;
			r.relay_wanted = t.relay_now;
			r.range_error = 1'b0;
			if (!auto_en) begin
				// automation off: hold everything
			end else if (spray_len < 1 || spray_len > SPRAY_MAX ||
					interval_h < 1 || interval_h > INTERVAL_MAX) begin
				r.range_error = 1'b1;
			end else if (!window_open(t.tick_hour * 60 + t.tick_minute)) begin
				r.relay_wanted = 1'b0;
				mark_sec = 0;
			end else begin
				now_sec = (t.tick_hour * HOUR_SEC + t.tick_minute * MINUTE_SEC + t.tick_second)
					& 32'h1FFFF;
				if (mark_sec == 0) begin
					r.relay_wanted = 1'b1;
					mark_sec = now_sec;
				end else begin
					// fold across midnight; saturate at zero for impossible ticks
					if (now_sec >= mark_sec)
						elapsed = now_sec - mark_sec;
					else if (DAY_SEC + now_sec >= mark_sec)
						elapsed = DAY_SEC + now_sec - mark_sec;
					else
						elapsed = 0;
					if (t.relay_now) begin
						if (elapsed >= spray_len) begin
							r.relay_wanted = 1'b0;
							mark_sec = now_sec;
						end
					end else if (elapsed >= interval_h * HOUR_SEC) begin
						r.relay_wanted = 1'b1;
						mark_sec = now_sec;
					end
				end
			end
			r.relay_change = r.relay_wanted != t.relay_now;
			return r;
		endfunction

		function void note_request(in_t t);
			out_t r;
			r = predict_relay(t);
			expected_q.push_back(r);
			last_wanted = r.relay_wanted;
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_q.size() == 0) begin
				$error("result %b arrived with no request outstanding", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.relay_wanted !== want.relay_wanted) begin
				$error("relay_wanted: expected %0b, actual %0b", want.relay_wanted,
					got.relay_wanted);
				errors++;
			end
			if (got.relay_change !== want.relay_change) begin
				$error("relay_change: expected %0b, actual %0b", want.relay_change,
					got.relay_change);
				errors++;
			end
			if (got.range_error !== want.range_error) begin
				$error("range_error: expected %0b, actual %0b", want.range_error,
					got.range_error);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	relay_scoreboard sb;

	bit          tx_gappy = 1'b1;
	bit          rx_pressure = 1'b1;
	int          stall_left = 0;
	int          cycle_count = 0;
	int unsigned clock_sec;

	windowed_interval_spray_timer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 2);
		if (r < 19)
			return $urandom_range(3, 8);
		return $urandom_range(20, 50);
	endfunction

	// Result side: check every accepted result, then pick the next stall state.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
		if (stall_left != 0)
			stall_left = stall_left - 1;
		else if (rx_pressure && $urandom_range(0, 5) == 0)
			stall_left = gap_len();
		out_stall <= (stall_left != 0);
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one request after an optional gap; hold it until the block takes it.
	task automatic send_request(input in_t t);
		int gap;
		gap = (tx_gappy && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (in_stall);
		sb.note_request(t);
	endtask

	task automatic send_time(input bit relay, input int h, input int m, input int s);
		in_t t;
		t.relay_now = relay;
		t.tick_hour = 5'(h);
		t.tick_minute = 6'(m);
		t.tick_second = 6'(s);
		send_request(t);
	endtask

	// Drop valid and let every outstanding result come back, then let the block idle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// Fill the bits above a register's width with garbage when asked; the block must drop them.
	function automatic logic [CFG_DATA_W-1:0] pad(input int v, input int w, input bit junk);
		logic [CFG_DATA_W-1:0] hi;
		hi = 7'($urandom) << w;
		return junk ? (7'(v) | hi) : 7'(v);
	endfunction

	task automatic apply_settings(input bit en, input int onh, input int onm, input int offh,
			input int offm, input int ivl, input int spray, input bit junk);
		wait_idle();
		program_reg(REG_AUTO_ENABLE, pad(en, 1, junk));
		program_reg(REG_WINDOW_ON_HOUR, pad(onh, 5, junk));
		program_reg(REG_WINDOW_ON_MINUTE, pad(onm, 6, junk));
		program_reg(REG_WINDOW_OFF_HOUR, pad(offh, 5, junk));
		program_reg(REG_WINDOW_OFF_MINUTE, pad(offm, 6, junk));
		program_reg(REG_INTERVAL_HOURS, pad(ivl, 4, junk));
		program_reg(REG_SPRAY_SECONDS, pad(spray, 7, junk));
		if (junk)
			program_reg(REG_SPARE, 7'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Advance the wall clock: mostly seconds, sometimes spray-length or interval-sized jumps.
	function automatic int unsigned clock_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return $urandom_range(1, 4);
		if (r < 70)
			return $urandom_range(5, 150);
		if (r < 90)
			return $urandom_range(600, 14400);
		return $urandom_range(0, DAY_SEC - 1);
	endfunction

	initial begin
		int  ph;
		int  n;
		bit  en;
		int  onh, onm, offh, offm, ivl, spray;
		bit  junk;
		bit  relay;

		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Automation off after reset: the relay state passes straight through.
		send_time(0, 0, 0, 0);
		send_time(1, 31, 63, 63);

		// Plain daytime window: open, spray, stop, wait the interval, spray, close.
		apply_settings(1, 8, 0, 20, 0, 1, 10, 0);
		send_time(1, 7, 59, 59);
		send_time(0, 8, 0, 0);
		send_time(1, 8, 0, 5);
		send_time(1, 8, 0, 10);
		send_time(0, 9, 0, 9);
		send_time(0, 9, 0, 10);
		send_time(1, 20, 0, 0);

		// Window across midnight: elapsed time wraps through the day boundary.
		apply_settings(1, 22, 0, 2, 0, 1, 10, 0);
		send_time(0, 23, 59, 50);
		send_time(1, 0, 0, 30);
		send_time(0, 1, 0, 30);
		// Hour beyond the day leaves a mark past midnight; the next tick saturates to zero.
		send_time(1, 31, 0, 0);
		send_time(0, 0, 0, 30);
		// Clear the mark, then start a spray exactly at midnight: the mark reads as empty.
		send_time(0, 12, 0, 0);
		send_time(0, 0, 0, 0);
		send_time(1, 0, 0, 1);

		// Equal on and off times keep the window shut.
		apply_settings(1, 5, 30, 5, 30, 1, 10, 0);
		send_time(1, 5, 30, 0);

		// Out-of-range duration and interval, both ends.
		apply_settings(1, 0, 0, 23, 59, 1, 0, 0);
		send_time(1, 12, 0, 0);
		apply_settings(1, 0, 0, 23, 59, 15, 127, 0);
		send_time(0, 12, 0, 0);
		apply_settings(1, 0, 0, 23, 59, 13, 99, 0);
		send_time(1, 12, 0, 0);
		apply_settings(1, 0, 0, 23, 59, 0, 99, 0);
		send_time(0, 12, 0, 0);
		apply_settings(1, 0, 0, 23, 59, 12, 100, 0);
		send_time(1, 12, 0, 0);
		// Automation off wins over a bad range.
		apply_settings(0, 0, 0, 23, 59, 0, 0, 0);
		send_time(1, 12, 0, 0);

		// Random phases: new settings each time, the clock walked with the relay fed back.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					en = 1; onh = 0; onm = 0; offh = 23; offm = 59; ivl = 1; spray = 1;
				end
				1: begin
					en = 1; onh = 23; onm = 59; offh = 0; offm = 0; ivl = 12; spray = 99;
				end
				2: begin
					en = 1; onh = 20; onm = 0; offh = 6; offm = 0; ivl = 12; spray = 99;
				end
				default: begin
					en = $urandom_range(0, 11) != 0;
					onh = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31)
						: $urandom_range(0, 23);
					onm = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63)
						: $urandom_range(0, 59);
					offh = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 31)
						: $urandom_range(0, 23);
					offm = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63)
						: $urandom_range(0, 59);
					if ($urandom_range(0, 9) == 0) begin
						offh = onh;
						offm = onm;
					end
					n = $urandom_range(0, 9);
					if (n == 0)
						ivl = $urandom_range(13, 16) % 16;
					else if (n < 6)
						ivl = $urandom_range(1, 3);
					else
						ivl = $urandom_range(1, 12);
					n = $urandom_range(0, 9);
					if (n == 0)
						spray = $urandom_range(100, 128) % 128;
					else if (n < 5)
						spray = $urandom_range(1, 20);
					else
						spray = $urandom_range(1, 99);
				end
			endcase
			junk = $urandom_range(0, 2) == 0;
			tx_gappy = $urandom_range(0, 3) != 0;
			rx_pressure = $urandom_range(0, 3) != 0;
			apply_settings(en, onh, onm, offh, offm, ivl, spray, junk);
			clock_sec = $urandom_range(0, DAY_SEC - 1);

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Now and then hold the sender until the block has drained.
				if ($urandom_range(0, 79) == 0)
					wait_idle();
				if ($urandom_range(0, 4) == 0) begin
					// Noise: any field value, any relay state.
					send_time($urandom_range(0, 1), $urandom_range(0, 31),
						$urandom_range(0, 63), $urandom_range(0, 63));
				end else begin
					clock_sec = (clock_sec + clock_step()) % DAY_SEC;
					relay = sb.last_wanted;
					if ($urandom_range(0, 19) == 0)
						relay = !relay;
					send_time(relay, clock_sec / HOUR_SEC, (clock_sec / MINUTE_SEC) % 60,
						clock_sec % MINUTE_SEC);
				end
			end
		end

		wait_idle();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
